// ===== rtl/srbs_pkg.sv =====
`timescale 1ns / 1ps

package srbs_pkg;

  // Field widths of the item and result channels
  localparam int OP_W  = 2;
  localparam int IDX_W = 10;
  localparam int POS_W = 11;
  localparam int VAL_W = 32;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_AFTER  = 2'd1;
  localparam logic [OP_W-1:0] OP_BEFORE = 2'd2;

  // Flip the sign bit: signed order becomes unsigned order
  localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;

  // Command kinds passed from front to back
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] CMD_WRITE  = 3'd0;
  localparam logic [KIND_W-1:0] CMD_AFTER  = 3'd1;
  localparam logic [KIND_W-1:0] CMD_BEFORE = 3'd2;
  localparam logic [KIND_W-1:0] CMD_DIRECT = 3'd3;
  localparam logic [KIND_W-1:0] CMD_ERROR  = 3'd4;

  // pos_a: write index, range start or direct result; pos_b: range end;
  // key: stored key or target key
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  pos_a;
    logic [POS_W-1:0]  pos_b;
    logic [VAL_W-1:0]  key;
  } cmd_t;

endpackage

// ===== rtl/srbs_in_if.sv =====
`timescale 1ns / 1ps

interface srbs_in_if import srbs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic [IDX_W-1:0]        write_index;
  logic signed [VAL_W-1:0] write_value;
  logic [IDX_W-1:0]        range_start;
  logic [POS_W-1:0]        range_end;
  logic signed [VAL_W-1:0] target;

  modport source (
    output valid, opcode, write_index, write_value, range_start, range_end, target,
    input  ready
  );
  modport sink (
    input  valid, opcode, write_index, write_value, range_start, range_end, target,
    output ready
  );
endinterface

// ===== rtl/srbs_out_if.sv =====
`timescale 1ns / 1ps

interface srbs_out_if import srbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] position;
  logic             range_error;

  modport source (
    output valid, position, range_error,
    input  ready
  );
  modport sink (
    input  valid, position, range_error,
    output ready
  );
endinterface

// ===== rtl/sorted_range_binary_search.sv =====
`timescale 1ns / 1ps

// Sorted-range binary search over a store of signed 32-bit values.
// req carries items: opcode 0 writes write_value at write_index; opcode 1
// finds the first position in [range_start, range_end) holding a value not
// below target (range_end if none); opcode 2 finds the last position in
// [range_start, range_end] not above target. An exact hit returns the probe.
// rsp carries one result per search: position, or range_error with position 0
// for an illegal range. Writes and unused opcodes give no result.
// A write is done by the back end as it takes the item. A search takes one
// read of the store for its first probe and one more per bisection step, so
// about log2(range length) reads. Each step is one read of the store's single read port.
// Error and empty-range items go straight to the result. A 2-entry command queue sits in
// front of the search engine, so new items are taken while a search runs.
// Reset empties the queue and the result register; the store is not cleared
// and entries must be written before a search reads them.
// When rsp is stalled the result holds in its register; the engine then
// waits with the next result and the queue fills until req deasserts ready.
module sorted_range_binary_search import srbs_pkg::*; #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic       clk,
  input  logic       rst,
  srbs_in_if.sink    req,
  srbs_out_if.source rsp
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Decode, range-check and key-convert each transfer
  srbs_front #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Decouple intake from the search engine
  srbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Store writes, bisection and result register
  srbs_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .rsp       (rsp)
  );

endmodule

// ===== rtl/srbs_ram.sv =====
`timescale 1ns / 1ps

module srbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srbs_front.sv =====
`timescale 1ns / 1ps

module srbs_front import srbs_pkg::*; #(
  parameter int STORE_DEPTH = 1024
) (
  srbs_in_if.sink req,
  output logic    push_valid,
  input  logic    push_ready,
  output cmd_t    push_cmd
);

  localparam logic [17:0] DEPTH_W = 18'(STORE_DEPTH);

  logic [17:0] idx_w;
  logic [17:0] end_w;
  logic [POS_W-1:0] start_p;
  logic keep;

  assign idx_w   = {8'b0, req.write_index};
  assign end_w   = {7'b0, req.range_end};
  assign start_p = {1'b0, req.range_start};

  // Classify the item; drop writes outside the store and unused opcodes
  always_comb begin
    keep           = 1'b1;
    push_cmd.kind  = CMD_ERROR;
    push_cmd.pos_a = start_p;
    push_cmd.pos_b = req.range_end;
    push_cmd.key   = req.target ^ SIGN_FLIP;
    case (req.opcode)
      OP_WRITE: begin
        push_cmd.kind  = CMD_WRITE;
        push_cmd.pos_a = {1'b0, req.write_index};
        push_cmd.key   = req.write_value ^ SIGN_FLIP;
        keep           = (idx_w < DEPTH_W);
      end
      OP_AFTER: begin
        if (start_p > req.range_end || end_w > DEPTH_W) begin
          push_cmd.kind = CMD_ERROR;
        end else if (start_p == req.range_end) begin
          push_cmd.kind = CMD_DIRECT;
        end else begin
          push_cmd.kind = CMD_AFTER;
        end
      end
      OP_BEFORE: begin
        if (start_p > req.range_end || end_w >= DEPTH_W) begin
          push_cmd.kind = CMD_ERROR;
        end else begin
          push_cmd.kind = CMD_BEFORE;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign req.ready  = push_ready;
  assign push_valid = req.valid && keep;

endmodule

// ===== rtl/srbs_queue.sv =====
`timescale 1ns / 1ps

module srbs_queue import srbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/srbs_back.sv =====
`timescale 1ns / 1ps

module srbs_back import srbs_pkg::*; #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  cmd_t        pop_cmd,
  srbs_out_if.source  rsp
);

  localparam int AW = $clog2(STORE_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FIRST = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  function automatic logic [AW-1:0] to_addr(input logic [POS_W-1:0] p);
    logic [AW+POS_W-1:0] ext;
    ext = {{AW{1'b0}}, p};
    return ext[AW-1:0];
  endfunction

  logic [1:0]       state, state_next;
  logic [POS_W-1:0] lo, lo_next;
  logic [POS_W-1:0] hi, hi_next;
  logic [POS_W-1:0] mid, mid_next;
  logic [VAL_W-1:0] tkey, tkey_next;
  logic             after_mode, after_mode_next;
  logic [POS_W-1:0] res_pos, res_pos_next;
  logic             res_err, res_err_next;
  logic             out_valid;
  logic [POS_W-1:0] out_pos;
  logic             out_err;

  logic             ram_we;
  logic [POS_W-1:0] ram_rpos;
  logic [VAL_W-1:0] dkey;

  logic [POS_W:0]   sum0, sum_a, sum_b;
  logic [POS_W-1:0] mid0, mid_a, mid_b;
  logic [POS_W-1:0] span0, span_a, span_b;
  logic             key_lt, key_gt, out_free, out_load;

  srbs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (to_addr(pop_cmd.pos_a)),
    .wdata (pop_cmd.key),
    .raddr (to_addr(ram_rpos)),
    .rdata (dkey)
  );

  // Both possible next probes come from registers; the compare only selects
  assign sum0   = {1'b0, lo} + {1'b0, hi};
  assign sum_a  = {1'b0, mid} + {1'b0, hi};
  assign sum_b  = {1'b0, lo} + {1'b0, mid};
  assign mid0   = sum0[POS_W:1];
  assign mid_a  = sum_a[POS_W:1];
  assign mid_b  = sum_b[POS_W:1];
  assign span0  = hi - lo;
  assign span_a = hi - mid;
  assign span_b = mid - lo;
  assign key_lt = dkey < tkey;
  assign key_gt = dkey > tkey;

  assign out_free  = !out_valid || rsp.ready;
  assign pop_ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && out_free;

  always_comb begin
    state_next      = state;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    tkey_next       = tkey;
    after_mode_next = after_mode;
    res_pos_next    = res_pos;
    res_err_next    = res_err;
    ram_we          = 1'b0;
    ram_rpos        = mid;
    case (state)
      S_IDLE: begin
        if (pop_valid) begin
          case (pop_cmd.kind)
            CMD_WRITE: begin
              ram_we = 1'b1;
            end
            CMD_AFTER, CMD_BEFORE: begin
              lo_next         = pop_cmd.pos_a;
              hi_next         = pop_cmd.pos_b;
              tkey_next       = pop_cmd.key;
              after_mode_next = (pop_cmd.kind == CMD_AFTER);
              ram_rpos        = (pop_cmd.kind == CMD_AFTER) ? pop_cmd.pos_a : pop_cmd.pos_b;
              state_next      = S_FIRST;
            end
            CMD_DIRECT: begin
              res_pos_next = pop_cmd.pos_a;
              res_err_next = 1'b0;
              state_next   = S_DONE;
            end
            default: begin
              res_pos_next = '0;
              res_err_next = 1'b1;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_FIRST: begin
        res_err_next = 1'b0;
        if (after_mode ? !key_lt : !key_gt) begin
          res_pos_next = after_mode ? lo : hi;
          state_next   = S_DONE;
        end else if (span0 > 11'd1) begin
          mid_next   = mid0;
          ram_rpos   = mid0;
          state_next = S_STEP;
        end else begin
          res_pos_next = after_mode ? hi : lo;
          state_next   = S_DONE;
        end
      end
      S_STEP: begin
        if (key_lt) begin
          lo_next = mid;
          if (span_a > 11'd1) begin
            mid_next = mid_a;
            ram_rpos = mid_a;
          end else begin
            res_pos_next = after_mode ? hi : mid;
            state_next   = S_DONE;
          end
        end else if (key_gt) begin
          hi_next = mid;
          if (span_b > 11'd1) begin
            mid_next = mid_b;
            ram_rpos = mid_b;
          end else begin
            res_pos_next = after_mode ? mid : lo;
            state_next   = S_DONE;
          end
        end else begin
          // exact match: report the probe
          res_pos_next = mid;
          state_next   = S_DONE;
        end
      end
      default: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    tkey       <= tkey_next;
    after_mode <= after_mode_next;
    res_pos    <= res_pos_next;
    res_err    <= res_err_next;
    if (out_load) begin
      out_pos <= res_pos;
      out_err <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.position    = out_pos;
  assign rsp.range_error = out_err;

endmodule
